>>> rtl/sfst_pkg.sv
`default_nettype none
package sfst_pkg;

   // Request operation codes.
   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_FIND   = 3'd1,
      OP_REMOVE = 3'd2,
      OP_POP    = 3'd3,
      OP_GET    = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_RANGE     = 3'd5
   } status_type;

   // Control that every cell of the chain sees in the same cycle.
   typedef struct packed {
      logic        cmp_en;
      logic        insert_en;
      logic        remove_en;
      logic [31:0] key;
   } cell_ctrl_type;

   localparam logic [31:0] ABS_MASK = 32'h7fff_ffff;
   localparam logic [31:0] INF_BITS = 32'h7f80_0000;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   function automatic logic is_nan(input logic [31:0] b);
      return (b & ABS_MASK) > INF_BITS;
   endfunction

   // Float equality: plus and minus zero match, NaN never matches.
   function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      return (a == b) || (((a | b) & ABS_MASK) == 32'd0);
   endfunction

   // Maps a binary32 pattern to an unsigned key with the same order.
   function automatic logic [31:0] order_key(input logic [31:0] b);
      return b[31] ? ~b : (b | SIGN_BIT);
   endfunction

   function automatic logic flt(input logic [31:0] a, input logic [31:0] b);
      if (is_nan(a) || is_nan(b) || feq(a, b)) return 1'b0;
      return order_key(a) < order_key(b);
   endfunction

endpackage
`default_nettype wire

>>> rtl/sfst_cell.sv
`default_nettype none
module sfst_cell (
   input  wire logic                   clock,
   input  wire sfst_pkg::cell_ctrl_type ctrl,
   input  wire logic                   live,
   input  wire logic                   prev_lt,
   input  wire logic [31:0]            prev_value,
   input  wire logic [31:0]            next_value,
   output logic [31:0]                 value,
   output logic                        lt,
   output logic                        eq
);
   import sfst_pkg::*;

   logic [31:0] value_ff, value_in;
   logic        lt_ff, lt_in, eq_ff, eq_in;

   // Compare the held entry against the key; dead cells never match.
   always_comb begin
      lt_in = lt_ff;
      eq_in = eq_ff;
      if (ctrl.cmp_en) begin
         lt_in = live && flt(value_ff, ctrl.key);
         eq_in = live && feq(value_ff, ctrl.key);
      end
   end

   // Shift: cells at or above the key position move up on insert, down on remove.
   always_comb begin
      value_in = value_ff;
      if (ctrl.insert_en && !lt_ff) begin
         value_in = prev_lt ? ctrl.key : prev_value;
      end else if (ctrl.remove_en && !lt_ff) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign value = value_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;
endmodule
`default_nettype wire

>>> rtl/sorted_float_set_table_top.sv
`default_nettype none
// Sorted binary32 set table built as a chain of compare-and-shift cells.
// Each request passes a compare state, then an apply state that waits until any
// held result is taken and then registers the result. A new request is accepted
// only when idle, after the shared compare/apply pass over all cells is done.
// Reset: synchronous, active high; clears the entry count and handshake state.
// Entry contents are not cleared.
module sorted_float_set_table_top #(
   parameter int CAPACITY = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // key_value[31:0], slot_index[37:32], zero pad
   input  wire logic [2:0]  req_tuser,   // req_type[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // position[5:0], read_value[37:6],
                                         // entry_total[44:38], zero pad
   output logic [2:0]       rsp_tuser    // status[2:0]
);
   import sfst_pkg::*;

   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int IDXW = $clog2(CAPACITY);
   localparam int SELW = (CNTW > 6) ? CNTW : 6;

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY} state_type;

   state_type            state_ff;
   logic [CNTW-1:0]      count_ff, count_in;
   logic [2:0]           op_ff;
   logic [31:0]          key_ff;
   logic [5:0]           slot_ff;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [5:0]           rsp_pos_ff, rsp_pos_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;

   cell_ctrl_type        ctrl;
   logic [CAPACITY-1:0]  live_vec, lt_vec, eq_vec, bound_vec;
   logic [31:0]          cell_value [CAPACITY];
   logic                 req_fire, apply_fire, found, full;
   logic [IDXW-1:0]      eq_idx, ins_idx;
   logic [CNTW-1:0]      ins_pos, rd_sel;
   logic [31:0]          rd_value;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign apply_fire = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);

   // Live mask from the entry count.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         live_vec[i] = (CNTW'(i) < count_ff);
      end
   end

   assign found = |eq_vec;
   assign full  = (count_ff == CNTW'(CAPACITY));

   assign ctrl.cmp_en    = (state_ff == S_CMP);
   assign ctrl.key       = key_ff;
   assign ctrl.insert_en = apply_fire && (op_ff == OP_INSERT) && !found && !full;
   assign ctrl.remove_en = apply_fire && (op_ff == OP_REMOVE) && found;

   // The cell chain.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      sfst_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .live       (live_vec[g]),
         .prev_lt    ((g == 0) ? 1'b1 : lt_vec[(g == 0) ? 0 : g - 1]),
         .prev_value (cell_value[(g == 0) ? 0 : g - 1]),
         .next_value (cell_value[(g == CAPACITY - 1) ? g : g + 1]),
         .value      (cell_value[g]),
         .lt         (lt_vec[g]),
         .eq         (eq_vec[g])
      );
   end

   // Position encoders: matching cell and first cell not below the key.
   always_comb begin
      eq_idx  = '0;
      ins_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         bound_vec[i] = !lt_vec[i] && ((i == 0) || lt_vec[(i == 0) ? 0 : i - 1]);
         if (eq_vec[i])    eq_idx  = eq_idx  | IDXW'(i);
         if (bound_vec[i]) ins_idx = ins_idx | IDXW'(i);
      end
      ins_pos = (|bound_vec) ? CNTW'(ins_idx) : count_ff;
   end

   // Read port for pop and get.
   always_comb begin
      rd_sel = (op_ff == OP_POP) ? (count_ff - CNTW'(1)) : CNTW'(slot_ff);
      rd_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_sel == CNTW'(i)) rd_value = cell_value[i];
      end
   end

   // Result and count update.
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_pos_in    = '0;
      rsp_value_in  = '0;
      count_in      = count_ff;
      case (op_ff)
         OP_INSERT: begin
            if (found) begin
               rsp_status_in = ST_DUPLICATE;
               rsp_pos_in    = 6'(eq_idx);
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_pos_in = 6'(ins_pos);
               count_in   = count_ff + CNTW'(1);
            end
         end
         OP_FIND: begin
            if (found) rsp_pos_in = 6'(eq_idx);
            else rsp_status_in = ST_NOT_FOUND;
         end
         OP_REMOVE: begin
            if (found) begin
               rsp_pos_in = 6'(eq_idx);
               count_in   = count_ff - CNTW'(1);
            end else begin
               rsp_status_in = ST_NOT_FOUND;
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_value_in = rd_value;
               count_in     = count_ff - CNTW'(1);
            end
         end
         OP_GET: begin
            if (SELW'(slot_ff) >= SELW'(count_ff)) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_value_in = rd_value;
            end
         end
         OP_CLEAR: count_in = '0;
         default: ;
      endcase
   end

   // Sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_fire) state_ff <= S_CMP;
            S_CMP: state_ff <= S_APPLY;
            S_APPLY: if (apply_fire) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
         if (apply_fire) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         op_ff   <= req_tuser;
         key_ff  <= req_tdata[31:0];
         slot_ff <= req_tdata[37:32];
      end
      if (apply_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, 7'(count_ff), rsp_value_ff, rsp_pos_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(CAPACITY)) else $error("entry count above capacity");
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> $onehot0(eq_vec)) else $error("several cells match");
   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_CMP)) else $error("accept did not start compare");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |=> (count_ff == $past(count_ff) + CNTW'(1)))
      else $error("insert did not grow count");
endmodule
`default_nettype wire

>>> tb/sorted_float_set_table_top_test.sv
`default_nettype none
module sorted_float_set_table_top_test;
   import sfst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 64;

   typedef struct packed {
      status_type  status;
      logic [5:0]  position;
      logic [31:0] read_value;
      logic [6:0]  entry_total;
   } table_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   sorted_float_set_table_top #(.CAPACITY(CAP)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the table used for prediction.
   logic [31:0]   shadow_store [CAP];
   int            shadow_count = 0;
   table_result_t pending_results [$];
   int            mismatch_count = 0;
   int            result_count = 0;
   int            sent_count = 0;
   bit            hold_off = 1'b0;
   int            op_seen [8];

   function automatic bit key_is_nan(logic [31:0] b);
      return (b & 32'h7fff_ffff) > 32'h7f80_0000;
   endfunction

   function automatic bit key_equal(logic [31:0] a, logic [31:0] b);
      if (key_is_nan(a) || key_is_nan(b)) return 1'b0;
      return a == b || ((a | b) & 32'h7fff_ffff) == 0;
   endfunction

   function automatic bit key_less(logic [31:0] a, logic [31:0] b);
      logic [31:0] ka, kb;
      if (key_is_nan(a) || key_is_nan(b) || key_equal(a, b)) return 1'b0;
      ka = a[31] ? ~a : (a | 32'h8000_0000);
      kb = b[31] ? ~b : (b | 32'h8000_0000);
      return ka < kb;
   endfunction

   // Binary search; returns 1 on a match, pos is the match or insertion point.
   function automatic bit search_table(logic [31:0] key, output int pos);
      int lo, hi, mid;
      lo = 0;
      hi = shadow_count - 1;
      while (hi >= lo) begin
         mid = lo + (hi - lo) / 2;
         if (key_equal(shadow_store[mid], key)) begin
            pos = mid;
            return 1'b1;
         end else if (key_less(shadow_store[mid], key)) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      pos = lo;
      return 1'b0;
   endfunction

   function automatic table_result_t predict_table_op(logic [2:0] op, logic [31:0] key,
                                                     logic [5:0] slot);
      table_result_t r;
      int p;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (search_table(key, p)) begin
               r.status = ST_DUPLICATE;
               r.position = 6'(p);
            end else if (shadow_count >= CAP) begin
               r.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > p; i--) shadow_store[i] = shadow_store[i-1];
               shadow_store[p] = key;
               shadow_count++;
               r.position = 6'(p);
            end
         end
         OP_FIND: begin
            if (search_table(key, p)) r.position = 6'(p);
            else r.status = ST_NOT_FOUND;
         end
         OP_REMOVE: begin
            for (p = 0; p < shadow_count; p++)
               if (key_equal(shadow_store[p], key)) break;
            if (p == shadow_count) begin
               r.status = ST_NOT_FOUND;
            end else begin
               shadow_count--;
               for (int i = p; i < shadow_count; i++) shadow_store[i] = shadow_store[i+1];
               r.position = 6'(p);
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               shadow_count--;
               r.read_value = shadow_store[shadow_count];
            end
         end
         OP_GET: begin
            if (slot >= shadow_count) r.status = ST_RANGE;
            else r.read_value = shadow_store[slot];
         end
         OP_CLEAR: shadow_count = 0;
         default: ;
      endcase
      r.entry_total = 7'(shadow_count);
      return r;
   endfunction

   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Sends one request and records its expected result on transfer.
   // Valid stays high after a transfer when the next request follows at once.
   task automatic send_request(logic [2:0] op, logic [31:0] key, logic [5:0] slot);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, slot, key};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_table_op(op, key, slot));
      op_seen[op]++;
      sent_count++;
   endtask

   // Random binary32 pattern without NaN, biased toward a small pool of values.
   function automatic logic [31:0] random_key();
      logic [31:0] k;
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
         k = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'h7f, 20'h0, 3'($urandom_range(0, 7))};
      end else if (roll == 5) begin
         k = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0;
      end else begin
         k = $urandom;
         if (key_is_nan(k)) k = k & 32'hff80_0000;
      end
      return k;
   endfunction

   // Response side: random stalls plus the long hold-off, and field checks.
   always @(posedge clock) begin
      table_result_t got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = status_type'(rsp_tuser);
            got.position    = rsp_tdata[5:0];
            got.read_value  = rsp_tdata[37:6];
            got.entry_total = rsp_tdata[44:38];
            result_count++;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected result %p", got);
            end else begin
               want = pending_results.pop_front();
               if (got !== want || rsp_tdata[47:45] !== 3'b0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d: expected %p, actual %p", result_count, want, got);
               end
            end
         end
         rsp_tready <= !hold_off && ($urandom_range(0, 99) < 70 ||
                                     $urandom_range(0, 9) == 0);
      end
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_extremes();
      send_request(OP_POP, 32'h0, 6'd0);
      send_request(OP_GET, 32'h0, 6'd0);
      send_request(OP_FIND, 32'h3f80_0000, 6'd0);
      send_request(OP_REMOVE, 32'h3f80_0000, 6'd0);
      send_request(OP_INSERT, 32'h0000_0000, 6'd0);
      send_request(OP_INSERT, 32'h8000_0000, 6'd0);
      send_request(OP_FIND, 32'h8000_0000, 6'd0);
      send_request(OP_INSERT, 32'hff80_0000, 6'd0);
      send_request(OP_INSERT, 32'h7f80_0000, 6'd0);
      send_request(OP_INSERT, 32'h7f7f_ffff, 6'd0);
      send_request(OP_INSERT, 32'h8000_0001, 6'd0);
      send_request(OP_INSERT, 32'h0000_0001, 6'd0);
      send_request(OP_GET, 32'hffff_ffff, 6'd63);
      send_request(OP_GET, 32'h0, 6'd2);
      send_request(OP_REMOVE, 32'h0000_0000, 6'd0);
      send_request(OP_POP, 32'h0, 6'd0);
      send_request(3'd6, 32'hffff_ffff, 6'd63);
      send_request(3'd7, 32'h0, 6'd0);
      send_request(OP_CLEAR, 32'h0, 6'd0);
      send_request(OP_GET, 32'h0, 6'd0);
   endtask

   // Starts filling the table to capacity while the receiver holds off, then overflows it.
   task automatic test_fill_and_full();
      hold_off = 1'b1;
      fork
         begin
            for (int i = 0; i < CAP; i++)
               send_request(OP_INSERT, {1'b0, 8'h80, 17'h0, 6'(CAP - 1 - i)}, 6'd0);
         end
         begin
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      send_request(OP_INSERT, 32'hbf80_0000, 6'd0);
      send_request(OP_INSERT, {1'b0, 8'h80, 23'd5}, 6'd0);
      send_request(OP_GET, 32'h0, 6'd63);
      send_request(OP_FIND, {1'b0, 8'h80, 23'd63}, 6'd0);
      send_request(OP_REMOVE, {1'b0, 8'h80, 23'd0}, 6'd0);
      send_request(OP_POP, 32'h0, 6'd0);
   endtask

   task automatic test_random_mix();
      logic [2:0] op;
      int roll;
      for (int n = 0; n < 520; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) op = OP_INSERT;
         else if (roll < 55) op = OP_FIND;
         else if (roll < 70) op = OP_REMOVE;
         else if (roll < 78) op = OP_POP;
         else if (roll < 95) op = OP_GET;
         else if (roll < 97) op = OP_CLEAR;
         else op = 3'($urandom_range(6, 7));
         send_request(op, random_key(), 6'($urandom_range(0, 63)));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_fill_and_full();
      test_random_mix();
      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests, checked %0d results, %0d mismatches.",
               sent_count, result_count, mismatch_count);
      $display("Per operation: ins %0d find %0d rem %0d pop %0d get %0d clr %0d other %0d",
               op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
               op_seen[6] + op_seen[7]);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("sorted_float_set_table_top: match");
      else
         $display("sorted_float_set_table_top: mismatch");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("sorted_float_set_table_top: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
